// File: sv/shtu_pkg.sv
// Package for the segment homography transform unit.
// Holds payload structs, coefficient set and divider lane types.
// No dependencies.
`timescale 1ns / 1ps
package shtu_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned PROD_W  = COEF_W + COORD_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned REM_W   = SUM_W + FRAC_W;
  localparam int unsigned QUO_W   = COORD_W + 1;
  localparam int unsigned CMP_W   = SUM_W + QUO_W;
  localparam int unsigned NUM_REGS = 5;
  localparam int unsigned ADDR_W  = 6;

  localparam logic [2:0] REG_H0_H1 = 3'd0;
  localparam logic [2:0] REG_H2_H3 = 3'd1;
  localparam logic [2:0] REG_H4_H5 = 3'd2;
  localparam logic [2:0] REG_H6_H7 = 3'd3;
  localparam logic [2:0] REG_H8    = 3'd4;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_in_t;

  typedef struct packed {
    coord_t new_start_x;
    coord_t new_start_y;
    coord_t new_end_x;
    coord_t new_end_y;
    logic   start_at_infinity;
    logic   end_at_infinity;
  } seg_out_t;

  typedef struct packed {
    coef_t [8:0] h;
  } coef_set_t;

  typedef struct packed {
    sum_t p;
    sum_t q;
    sum_t r;
  } point_sums_t;

  // One quotient in flight through the divider row
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [SUM_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             num_zero;
  } div_lane_t;

endpackage

// File: sv/shtu_point_mac.sv
// Two-stage multiply-add producing p, q, r for one endpoint.
// Depends on shtu_pkg.
`timescale 1ns / 1ps
module shtu_point_mac import shtu_pkg::*; (
  input  logic        clk,
  input  coef_set_t   coefs,
  input  coord_t      x,
  input  coord_t      y,
  output point_sums_t sums
);

  logic signed [PROD_W-1:0] prod_r [6];
  logic signed [PROD_W-1:0] prod_nxt [6];
  logic signed [COEF_W+FRAC_W-1:0] cterm_r [3];
  logic signed [COEF_W+FRAC_W-1:0] cterm_nxt [3];
  point_sums_t sums_r;
  point_sums_t sums_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[2*k]   = PROD_W'(coefs.h[3*k])   * PROD_W'(x);
      prod_nxt[2*k+1] = PROD_W'(coefs.h[3*k+1]) * PROD_W'(y);
      cterm_nxt[k]    = {coefs.h[3*k+2], FRAC_W'(0)};
    end
  end

  always_comb begin
    sums_nxt.p = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(cterm_r[0]);
    sums_nxt.q = SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]) + SUM_W'(cterm_r[1]);
    sums_nxt.r = SUM_W'(prod_r[4]) + SUM_W'(prod_r[5]) + SUM_W'(cterm_r[2]);
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    cterm_r <= cterm_nxt;
    sums_r  <= sums_nxt;
  end

  assign sums = sums_r;

endmodule

// File: sv/shtu_div_cell.sv
// One restoring-division cell: decides quotient bit BIT and passes the lane on.
// Depends on shtu_pkg.
`timescale 1ns / 1ps
module shtu_div_cell import shtu_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic      clk,
  input  div_lane_t lane_i,
  output div_lane_t lane_o
);

  div_lane_t lane_r;
  div_lane_t lane_nxt;
  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] den_ext;

  always_comb begin
    rem_ext  = CMP_W'(lane_i.rem);
    den_ext  = CMP_W'(lane_i.den) << BIT;
    lane_nxt = lane_i;
    if (rem_ext >= den_ext) begin
      lane_nxt.rem = REM_W'(rem_ext - den_ext);
      lane_nxt.quo = lane_i.quo | (QUO_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_o = lane_r;

endmodule

// File: sv/segment_homography_transform_unit.sv
// Top level of the segment homography transform unit.
// Depends on shtu_pkg, shtu_point_mac, shtu_div_cell.
`timescale 1ns / 1ps
//
// Channel   Ports                              Transfer
// -------   --------------------------------   ------------------------------
// input     start, busy, in_segment            start && !busy at clk edge
// result    out_valid, out_result              out_valid for one cycle
// config    psel penable pwrite paddr pwdata   psel && penable && pwrite
//           prdata pready                      (pready tied high)
//
// One segment per cycle. Pipeline: input register, two MAC stages,
// lane setup, 25 divider cells (quotient bits 24..0), output stage.
// busy stays low; the divider row is a chain of cells, one bit each.
// Reset clears the valid pipeline and loads the identity matrix.
// The receiver cannot stall; each result shows for exactly one cycle.
module segment_homography_transform_unit import shtu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  seg_in_t           in_segment,
  output logic              out_valid,
  output seg_out_t          out_result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam int unsigned LAT = 30;
  localparam int unsigned VLD_W = LAT - 1;

  // Config registers
  logic [63:0] coef_r [NUM_REGS];
  logic [2:0]  reg_idx;
  coef_set_t   coefs;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_H0_H1] <= 64'd1048576;
      coef_r[REG_H2_H3] <= 64'd0;
      coef_r[REG_H4_H5] <= 64'd1048576;
      coef_r[REG_H6_H7] <= 64'd0;
      coef_r[REG_H8]    <= 64'd1048576;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_H0_H1: coef_r[REG_H0_H1] <= pwdata;
        REG_H2_H3: coef_r[REG_H2_H3] <= pwdata;
        REG_H4_H5: coef_r[REG_H4_H5] <= pwdata;
        REG_H6_H7: coef_r[REG_H6_H7] <= pwdata;
        REG_H8:    coef_r[REG_H8]    <= {32'd0, pwdata[31:0]};
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_H0_H1: prdata = coef_r[REG_H0_H1];
      REG_H2_H3: prdata = coef_r[REG_H2_H3];
      REG_H4_H5: prdata = coef_r[REG_H4_H5];
      REG_H6_H7: prdata = coef_r[REG_H6_H7];
      REG_H8:    prdata = coef_r[REG_H8];
      default:   prdata = 64'd0;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      coefs.h[2*k]   = coef_t'(coef_r[k][31:0]);
      coefs.h[2*k+1] = coef_t'(coef_r[k][63:32]);
    end
    coefs.h[8] = coef_t'(coef_r[REG_H8][31:0]);
  end

  // Valid pipeline; out_valid is its last stage
  logic [VLD_W-1:0] vld_r;
  logic [VLD_W-1:0] vld_nxt;
  logic             out_valid_r;

  assign vld_nxt = {vld_r[VLD_W-2:0], start && !busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[VLD_W-1];
    end
  end

  assign out_valid = out_valid_r;

  // Input register (no handshake hold needed: busy stays low)
  seg_in_t seg_r;

  always_ff @(posedge clk) begin
    seg_r <= in_segment;
  end

  // p, q, r for both endpoints
  point_sums_t sums_s;
  point_sums_t sums_e;

  shtu_point_mac u_mac_start (
    .clk   (clk),
    .coefs (coefs),
    .x     (seg_r.start_x),
    .y     (seg_r.start_y),
    .sums  (sums_s)
  );

  shtu_point_mac u_mac_end (
    .clk   (clk),
    .coefs (coefs),
    .x     (seg_r.end_x),
    .y     (seg_r.end_y),
    .sums  (sums_e)
  );

  // Lane setup: lanes 0..3 = start x, start y, end x, end y
  function automatic div_lane_t mk_lane(sum_t num, sum_t den);
    div_lane_t l;
    logic [SUM_W-1:0] n;
    n          = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    l.rem      = {n, FRAC_W'(0)};
    l.den      = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
    l.quo      = '0;
    l.neg      = num[SUM_W-1] ^ den[SUM_W-1];
    l.num_zero = (num == '0);
    return l;
  endfunction

  div_lane_t lane_r [4];

  always_ff @(posedge clk) begin
    lane_r[0] <= mk_lane(sums_s.p, sums_s.r);
    lane_r[1] <= mk_lane(sums_s.q, sums_s.r);
    lane_r[2] <= mk_lane(sums_e.p, sums_e.r);
    lane_r[3] <= mk_lane(sums_e.q, sums_e.r);
  end

  // Divider row: cell c handles quotient bit QUO_W-1-c
  div_lane_t chain [4][QUO_W+1];

  for (genvar ln = 0; ln < 4; ln++) begin : g_lane
    assign chain[ln][0] = lane_r[ln];
    for (genvar c = 0; c < QUO_W; c++) begin : g_cell
      shtu_div_cell #(.BIT(QUO_W - 1 - c)) u_cell (
        .clk    (clk),
        .lane_i (chain[ln][c]),
        .lane_o (chain[ln][c+1])
      );
    end
  end

  // Saturation; zero denominator gives all-ones quotient, so it saturates
  // by numerator sign (zero if the numerator is zero) with no extra path
  function automatic coord_t sat_q(div_lane_t l);
    coord_t res;
    if (l.num_zero) begin
      res = '0;
    end else if (l.neg) begin
      res = (l.quo > QUO_W'(8388608)) ? COORD_MIN : COORD_W'(QUO_W'(0) - l.quo);
    end else begin
      res = (l.quo > QUO_W'(8388607)) ? COORD_MAX : COORD_W'(l.quo);
    end
    return res;
  endfunction

  seg_out_t res_r;
  seg_out_t res_nxt;

  always_comb begin
    res_nxt.new_start_x       = sat_q(chain[0][QUO_W]);
    res_nxt.new_start_y       = sat_q(chain[1][QUO_W]);
    res_nxt.new_end_x         = sat_q(chain[2][QUO_W]);
    res_nxt.new_end_y         = sat_q(chain[3][QUO_W]);
    res_nxt.start_at_infinity = (chain[0][QUO_W].den == '0);
    res_nxt.end_at_infinity   = (chain[2][QUO_W].den == '0);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_result = res_r;

  // Assertions
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##30 out_valid)
    else $error("result missing after fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 30))
    else $error("result without a transfer");

  a_inf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.start_at_infinity) |->
      (out_result.new_start_x == COORD_MAX || out_result.new_start_x == COORD_MIN ||
       out_result.new_start_x == '0))
    else $error("infinite point not saturated");

endmodule
